[hw/rtl/pzd_pkg.sv]
// Shared types, codes and constants for the four-finger pinch-zoom detector.
package pzd_pkg;

    // Sizes
    localparam int FINGERS_DEF = 4;
    localparam int COORD_BITS  = 16;
    localparam int SLOT_W      = 4;
    localparam int KIND_W      = 3;
    localparam int THRESH_W    = 16;
    localparam int CNT_W       = 4;
    localparam int ADDR_W      = 3;
    localparam int IDX_W       = ADDR_W - 2;
    localparam int DATA_W      = 32;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd240;
    localparam logic [CNT_W-1:0]    COUNT_MAX    = 4'd15;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_ZOOM_THRESHOLD = 1'b0;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_DOWN   = 3'd0;
    localparam logic [KIND_W-1:0] EV_MOTION = 3'd1;
    localparam logic [KIND_W-1:0] EV_UP     = 3'd2;
    localparam logic [KIND_W-1:0] EV_FRAME  = 3'd3;
    localparam logic [KIND_W-1:0] EV_CANCEL = 3'd4;
    localparam logic [KIND_W-1:0] EV_CLEAR  = 3'd5;

    // Status codes
    localparam logic [2:0] ST_IGNORE    = 3'd0;
    localparam logic [2:0] ST_MAYBE     = 3'd1;
    localparam logic [2:0] ST_UPDATE    = 3'd2;
    localparam logic [2:0] ST_FINISHED  = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;

    // Zoom directions
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_IN   = 2'd1;
    localparam logic [1:0] DIR_OUT  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]     event_kind;
        logic [SLOT_W-1:0]     touch_slot;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } evt_t;

    typedef struct packed {
        logic [2:0] status_code;
        logic [1:0] recent_direction;
        logic [1:0] overall_direction;
    } res_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } point_t;

    // Direction view of the gesture state, core to top level
    typedef struct packed {
        logic [1:0] recent;
        logic [1:0] overall;
    } dir_view_t;

    // Width of a summed Manhattan spread over all fingers
    function automatic int sum_width(input int fingers);
        return COORD_BITS + 1 + $clog2(fingers);
    endfunction

endpackage

[hw/rtl/pzd_spread.sv]
// Summed Manhattan spread from finger 0 to every other finger.
module pzd_spread #(
    parameter int FINGERS = pzd_pkg::FINGERS_DEF,
    parameter int SUM_W   = pzd_pkg::sum_width(FINGERS)
) (
    input  pzd_pkg::point_t [FINGERS-1:0] pts,
    output logic [SUM_W-1:0]              sum
);

    logic [pzd_pkg::COORD_BITS-1:0] dx [1:FINGERS-1];
    logic [pzd_pkg::COORD_BITS-1:0] dy [1:FINGERS-1];

    // Take per-finger absolute offsets against finger 0
    for (genvar g = 1; g < FINGERS; g++) begin : g_diff
        assign dx[g] = (pts[0].x > pts[g].x) ? pts[0].x - pts[g].x : pts[g].x - pts[0].x;
        assign dy[g] = (pts[0].y > pts[g].y) ? pts[0].y - pts[g].y : pts[g].y - pts[0].y;
    end

    // Add up all offsets
    always_comb
    begin
        sum = '0;
        for (int i = 1; i < FINGERS; i++)
        begin
            sum = sum + SUM_W'(dx[i]) + SUM_W'(dy[i]);
        end
    end

endmodule

[hw/rtl/pzd_core.sv]
// Gesture state and single-pass event handling.
module pzd_core #(
    parameter int FINGERS = pzd_pkg::FINGERS_DEF,
    parameter int SUM_W   = pzd_pkg::sum_width(FINGERS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  pzd_pkg::evt_t      item,
    input  logic [SUM_W-1:0]   limit,
    output logic [2:0]         status,
    output pzd_pkg::dir_view_t view
);

    localparam logic [pzd_pkg::CNT_W-1:0] FING_CNT = pzd_pkg::CNT_W'(FINGERS);

    logic [pzd_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      cancelled_reg, cancelled_next;
    logic                      started_reg, started_next;
    logic [1:0]                last_dir_reg, last_dir_next;

    pzd_pkg::point_t [FINGERS-1:0] start_reg, start_next;
    pzd_pkg::point_t [FINGERS-1:0] last_reg, last_next;
    pzd_pkg::point_t [FINGERS-1:0] cur_reg, cur_next;

    logic [SUM_W-1:0] s_start, s_last, s_cur;

    pzd_spread #(.FINGERS(FINGERS), .SUM_W(SUM_W)) u_sp_start (.pts(start_reg), .sum(s_start));
    pzd_spread #(.FINGERS(FINGERS), .SUM_W(SUM_W)) u_sp_last  (.pts(last_reg),  .sum(s_last));
    pzd_spread #(.FINGERS(FINGERS), .SUM_W(SUM_W)) u_sp_cur   (.pts(cur_reg),   .sum(s_cur));

    // Handle one event against the current state
    always_comb
    begin
        pzd_pkg::point_t           pt;
        logic [pzd_pkg::CNT_W-1:0] cnt_up;
        logic [pzd_pkg::CNT_W-1:0] cnt_dn;
        logic [SUM_W-1:0]          chg;

        pt.x   = item.pos_x;
        pt.y   = item.pos_y;
        cnt_up = (count_reg != pzd_pkg::COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        cnt_dn = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
        chg    = (s_cur >= s_last) ? s_cur - s_last : s_last - s_cur;

        count_next     = count_reg;
        cancelled_next = cancelled_reg;
        started_next   = started_reg;
        last_dir_next  = last_dir_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        cur_next       = cur_reg;
        status         = pzd_pkg::ST_IGNORE;

        if (go)
        begin
            unique case (item.event_kind)
                pzd_pkg::EV_DOWN:
                begin
                    count_next = cnt_up;
                    if (!cancelled_reg)
                    begin
                        // Record start point while the gesture is still forming
                        if (cnt_up <= FING_CNT)
                        begin
                            for (int i = 0; i < FINGERS; i++)
                            begin
                                if (item.touch_slot == pzd_pkg::SLOT_W'(i))
                                    start_next[i] = pt;
                            end
                        end
                        if (cnt_up == FING_CNT)
                        begin
                            started_next = 1'b1;
                            last_next    = start_next;
                            cur_next     = start_next;
                            status       = pzd_pkg::ST_MAYBE;
                        end
                        else if (cnt_up > FING_CNT)
                        begin
                            cancelled_next = 1'b1;
                            status         = pzd_pkg::ST_CANCELLED;
                        end
                    end
                end
                pzd_pkg::EV_MOTION:
                begin
                    if (!cancelled_reg && started_reg)
                    begin
                        for (int i = 0; i < FINGERS; i++)
                        begin
                            if (item.touch_slot == pzd_pkg::SLOT_W'(i))
                                cur_next[i] = pt;
                        end
                    end
                end
                pzd_pkg::EV_UP:
                begin
                    count_next = cnt_dn;
                    if (cnt_dn == '0)
                    begin
                        // Last finger gone: finish a live gesture, else drop it
                        if (!cancelled_reg && started_reg && last_dir_reg != pzd_pkg::DIR_NONE)
                        begin
                            status = pzd_pkg::ST_FINISHED;
                        end
                        else
                        begin
                            cancelled_next = 1'b0;
                            started_next   = 1'b0;
                            last_dir_next  = pzd_pkg::DIR_NONE;
                            start_next     = '0;
                            last_next      = '0;
                            cur_next       = '0;
                        end
                    end
                end
                pzd_pkg::EV_FRAME:
                begin
                    if (!cancelled_reg && started_reg && !(chg < limit))
                    begin
                        last_next     = cur_reg;
                        last_dir_next = (s_cur > s_last) ? pzd_pkg::DIR_IN : pzd_pkg::DIR_OUT;
                        status        = pzd_pkg::ST_UPDATE;
                    end
                end
                pzd_pkg::EV_CANCEL:
                begin
                    cancelled_next = 1'b1;
                    status         = pzd_pkg::ST_CANCELLED;
                end
                pzd_pkg::EV_CLEAR:
                begin
                    cancelled_next = 1'b0;
                    started_next   = 1'b0;
                    last_dir_next  = pzd_pkg::DIR_NONE;
                    start_next     = '0;
                    last_next      = '0;
                    cur_next       = '0;
                end
                default:
                begin
                    status = pzd_pkg::ST_IGNORE;
                end
            endcase
        end
    end

    // Compare start spread against current spread
    always_comb
    begin
        view.recent = last_dir_reg;
        if (s_cur > s_start && (s_cur - s_start) > limit)
            view.overall = pzd_pkg::DIR_IN;
        else if (s_start > s_cur && (s_start - s_cur) > limit)
            view.overall = pzd_pkg::DIR_OUT;
        else
            view.overall = pzd_pkg::DIR_NONE;
    end

    // Hold gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cancelled_reg <= 1'b0;
            started_reg   <= 1'b0;
            last_dir_reg  <= pzd_pkg::DIR_NONE;
            start_reg     <= '0;
            last_reg      <= '0;
            cur_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            cancelled_reg <= cancelled_next;
            started_reg   <= started_next;
            last_dir_reg  <= last_dir_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            cur_reg       <= cur_next;
        end
    end

endmodule

[hw/rtl/four_finger_pinch_zoom_detector_unit.sv]
// Top level of the four-finger pinch-zoom detector: register port, event and result channels.
//
// Usage:
//   Touch events enter on the evt channel (evt_valid / evt_stall / evt_data); a transfer
//   happens at a rising edge with evt_valid high and evt_stall low. Every event gives
//   exactly one result on the res channel (res_valid / res_stall / res_data): status
//   code, last zoom direction and overall direction since the gesture started.
//   An event passes the event register, then the gesture logic and the result register.
//   Throughput: one event per cycle unless the receiver stalls. The event register feeds
//   the gesture logic, which updates its state and the result register in the same cycle,
//   so one gesture evaluation (three spread sums and their compares) sets the cycle time.
//   When the receiver stalls, the result holds; the event register keeps accepting
//   until it holds an event of its own, then evt_stall rises until the result is taken.
//   zoom_threshold lies at byte address 0 of the APB port; write it only while idle.
//   Reset clears the finger count, gesture flags and all stored points, empties both
//   registers and sets zoom_threshold to 240. No clearing pass is needed after reset.
module four_finger_pinch_zoom_detector_unit #(
    parameter int FINGERS = pzd_pkg::FINGERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pzd_pkg::ADDR_W-1:0]   paddr,
    input  logic [pzd_pkg::DATA_W-1:0]   pwdata,
    output logic [pzd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         evt_valid,
    output logic                         evt_stall,
    input  pzd_pkg::evt_t                evt_data,
    output logic                         res_valid,
    input  logic                         res_stall,
    output pzd_pkg::res_t                res_data
);

    localparam int SUM_W = pzd_pkg::sum_width(FINGERS);

    logic [pzd_pkg::THRESH_W-1:0] thresh_reg;
    logic [SUM_W-1:0]             limit_reg;
    logic [pzd_pkg::IDX_W-1:0]    reg_idx;
    logic                         cfg_wr;

    logic               evt_valid_reg;
    pzd_pkg::evt_t      evt_item_reg;
    logic               res_valid_reg;
    logic [2:0]         res_status_reg;
    logic               go;
    logic [2:0]         status;
    pzd_pkg::dir_view_t view;

    // Register port decode
    assign reg_idx = paddr[pzd_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (reg_idx == pzd_pkg::REG_ZOOM_THRESHOLD);
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == pzd_pkg::REG_ZOOM_THRESHOLD) ?
                     pzd_pkg::DATA_W'(thresh_reg) : '0;

    // Hold threshold and its scaled compare limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= pzd_pkg::THRESH_RESET;
            limit_reg  <= SUM_W'(pzd_pkg::THRESH_RESET) * SUM_W'(FINGERS - 1);
        end
        else if (cfg_wr)
        begin
            thresh_reg <= pwdata[pzd_pkg::THRESH_W-1:0];
            limit_reg  <= SUM_W'(pwdata[pzd_pkg::THRESH_W-1:0]) * SUM_W'(FINGERS - 1);
        end
    end

    // Advance the event register unless it is full and the result cannot move
    assign go        = evt_valid_reg && !(res_valid_reg && res_stall);
    assign evt_stall = evt_valid_reg && res_valid_reg && res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (!evt_stall)
            evt_valid_reg <= evt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && !evt_stall)
            evt_item_reg <= evt_data;
    end

    pzd_core #(.FINGERS(FINGERS), .SUM_W(SUM_W)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (evt_item_reg),
        .limit  (limit_reg),
        .status (status),
        .view   (view)
    );

    // Result register: load on each handled event, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (go)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go)
            res_status_reg <= status;
    end

    // Directions come from the gesture state, which only moves with the result register
    assign res_valid                  = res_valid_reg;
    assign res_data.status_code       = res_status_reg;
    assign res_data.recent_direction  = view.recent;
    assign res_data.overall_direction = view.overall;

endmodule

[hw/rtl/pzd_checker.sv]
// Port-level checks for the pinch-zoom detector, bound to the top level.
module pzd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_stall,
    input pzd_pkg::res_t              res_data,
    input logic [pzd_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
        else $error("stalled result changed");

    // An update or a finish always carries a zoom direction
    a_dir_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status_code == pzd_pkg::ST_UPDATE ||
                      res_data.status_code == pzd_pkg::ST_FINISHED)
        |-> res_data.recent_direction != pzd_pkg::DIR_NONE)
        else $error("update or finish without direction");

    // Register port never waits and reads back at most the threshold width
    a_port: assert property (@(posedge clk) disable iff (!rst_n)
        pready && prdata[pzd_pkg::DATA_W-1:pzd_pkg::THRESH_W] == '0)
        else $error("register port readback out of range");

endmodule

bind four_finger_pinch_zoom_detector_unit pzd_checker u_pzd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .prdata    (prdata),
    .pready    (pready)
);

[dv/four_finger_pinch_zoom_detector_unit_tb.sv]
// Self-checking testbench for the four-finger pinch-zoom detector unit.
`timescale 1ns / 1ps

module four_finger_pinch_zoom_detector_unit_tb;

    localparam int NUM_FINGERS = pzd_pkg::FINGERS_DEF;
    localparam int COORD_MAX   = (1 << pzd_pkg::COORD_BITS) - 1;

    // Event kinds the block treats as no-ops
    localparam logic [pzd_pkg::KIND_W-1:0] EV_SPARE_LO = 3'd6;
    localparam logic [pzd_pkg::KIND_W-1:0] EV_SPARE_HI = 3'd7;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [pzd_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [pzd_pkg::DATA_W-1:0]   pwdata    = '0;
    logic [pzd_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         evt_valid = 1'b0;
    logic                         evt_stall;
    pzd_pkg::evt_t                evt_data  = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    pzd_pkg::res_t                res_data;

    // Stimulus and scoreboard storage
    pzd_pkg::evt_t queued_touches [$];
    pzd_pkg::res_t pending_outcomes [$];
    pzd_pkg::res_t oldest_outcome;
    int   touches_queued   = 0;
    int   finger_tally     = 0;
    int   mismatch_count   = 0;
    int   send_idle_pct    = 0;
    int   recv_stall_pct   = 0;
    logic hold_off         = 1'b0;
    bit   pressure_go      = 1'b0;

    // Shadow of the gesture state
    logic [pzd_pkg::THRESH_W-1:0]        zoom_thr = pzd_pkg::THRESH_RESET;
    logic [pzd_pkg::CNT_W-1:0]           fingers_down;
    logic                                gesture_cancelled;
    logic                                gesture_started;
    logic [1:0]                          last_zoom;
    pzd_pkg::point_t [NUM_FINGERS-1:0]   start_pts;
    pzd_pkg::point_t [NUM_FINGERS-1:0]   last_pts;
    pzd_pkg::point_t [NUM_FINGERS-1:0]   cur_pts;

    four_finger_pinch_zoom_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Gesture predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] coord_gap(input logic [pzd_pkg::COORD_BITS-1:0] a,
                                              input logic [pzd_pkg::COORD_BITS-1:0] b);
        return (a > b) ? 32'(a - b) : 32'(b - a);
    endfunction

    // Sum of Manhattan distances from finger 0 to every other finger
    function automatic logic [31:0] finger_spread(
        input pzd_pkg::point_t [NUM_FINGERS-1:0] pts);
        logic [31:0] sum;
        sum = '0;
        for (int i = 1; i < NUM_FINGERS; i++)
        begin
            sum += coord_gap(pts[0].x, pts[i].x) + coord_gap(pts[0].y, pts[i].y);
        end
        return sum;
    endfunction

    function automatic logic [31:0] spread_limit();
        return 32'(NUM_FINGERS - 1) * 32'(zoom_thr);
    endfunction

    function automatic void reset_gesture();
        gesture_cancelled = 1'b0;
        gesture_started   = 1'b0;
        last_zoom         = pzd_pkg::DIR_NONE;
        start_pts         = '0;
        last_pts          = '0;
        cur_pts           = '0;
    endfunction

    // Advance the shadow state by one event and return its outcome
    function automatic pzd_pkg::res_t gesture_outcome(input pzd_pkg::evt_t ev);
        pzd_pkg::res_t   outc;
        pzd_pkg::point_t pt;
        logic            slot_ok;
        int              slot;
        logic [31:0]     sa;
        logic [31:0]     sb;
        logic [31:0]     lim;
        pt.x    = ev.pos_x;
        pt.y    = ev.pos_y;
        slot    = int'(ev.touch_slot);
        slot_ok = slot < NUM_FINGERS;
        lim     = spread_limit();
        outc.status_code = pzd_pkg::ST_IGNORE;
        case (ev.event_kind)
            pzd_pkg::EV_DOWN:
            begin
                if (fingers_down != pzd_pkg::COUNT_MAX)
                    fingers_down++;
                if (!gesture_cancelled)
                begin
                    if (int'(fingers_down) <= NUM_FINGERS && slot_ok)
                        start_pts[slot] = pt;
                    if (int'(fingers_down) == NUM_FINGERS)
                    begin
                        gesture_started  = 1'b1;
                        last_pts         = start_pts;
                        cur_pts          = start_pts;
                        outc.status_code = pzd_pkg::ST_MAYBE;
                    end
                    else if (int'(fingers_down) > NUM_FINGERS)
                    begin
                        gesture_cancelled = 1'b1;
                        outc.status_code  = pzd_pkg::ST_CANCELLED;
                    end
                end
            end
            pzd_pkg::EV_MOTION:
            begin
                if (!gesture_cancelled && gesture_started && slot_ok)
                    cur_pts[slot] = pt;
            end
            pzd_pkg::EV_UP:
            begin
                if (fingers_down != '0)
                    fingers_down--;
                if (fingers_down == '0)
                begin
                    if (!gesture_cancelled && gesture_started &&
                        last_zoom != pzd_pkg::DIR_NONE)
                        outc.status_code = pzd_pkg::ST_FINISHED;
                    else
                        reset_gesture();
                end
            end
            pzd_pkg::EV_FRAME:
            begin
                if (!gesture_cancelled && gesture_started)
                begin
                    sa = finger_spread(last_pts);
                    sb = finger_spread(cur_pts);
                    if (!(((sb > sa) ? sb - sa : sa - sb) < lim))
                    begin
                        last_pts         = cur_pts;
                        last_zoom        = (sb > sa) ? pzd_pkg::DIR_IN : pzd_pkg::DIR_OUT;
                        outc.status_code = pzd_pkg::ST_UPDATE;
                    end
                end
            end
            pzd_pkg::EV_CANCEL:
            begin
                gesture_cancelled = 1'b1;
                outc.status_code  = pzd_pkg::ST_CANCELLED;
            end
            pzd_pkg::EV_CLEAR:
            begin
                reset_gesture();
            end
            default:
            begin
            end
        endcase
        // Overall direction compares the start spread with the current one
        sa = finger_spread(start_pts);
        sb = finger_spread(cur_pts);
        outc.recent_direction = last_zoom;
        if (sb > sa && sb - sa > lim)
            outc.overall_direction = pzd_pkg::DIR_IN;
        else if (sa > sb && sa - sb > lim)
            outc.overall_direction = pzd_pkg::DIR_OUT;
        else
            outc.overall_direction = pzd_pkg::DIR_NONE;
        return outc;
    endfunction

    // ---------------------------------------------------------------
    // Driver: offer queued touches, record the outcome of each transfer
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
            evt_data  <= '0;
        end
        else
        begin
            if (evt_valid && !evt_stall)
                pending_outcomes.push_back(gesture_outcome(evt_data));
            // Hold a stalled payload; otherwise load the next one or idle
            if (!evt_valid || !evt_stall)
            begin
                if (queued_touches.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    evt_valid <= 1'b1;
                    evt_data  <= queued_touches.pop_front();
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each result transfer against the oldest outcome
    // ---------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [2:0] got,
                               input logic [2:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0d, predicted %0d", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result status %0d recent %0d overall %0d",
                                           res_data.status_code, res_data.recent_direction,
                                           res_data.overall_direction));
                end
                else
                begin
                    oldest_outcome = pending_outcomes.pop_front();
                    check_field("status_code", res_data.status_code,
                                oldest_outcome.status_code);
                    check_field("recent_direction", 3'(res_data.recent_direction),
                                3'(oldest_outcome.recent_direction));
                    check_field("overall_direction", 3'(res_data.overall_direction),
                                3'(oldest_outcome.overall_direction));
                end
            end
            res_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [pzd_pkg::COORD_BITS-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_MAX[pzd_pkg::COORD_BITS-1:0];
        return v[pzd_pkg::COORD_BITS-1:0];
    endfunction

    task automatic queue_touch(input logic [pzd_pkg::KIND_W-1:0] kind, input int slot,
                               input int x, input int y);
        pzd_pkg::evt_t ev;
        ev.event_kind = kind;
        ev.touch_slot = slot[pzd_pkg::SLOT_W-1:0];
        ev.pos_x      = clamp_coord(x);
        ev.pos_y      = clamp_coord(y);
        queued_touches.push_back(ev);
        touches_queued++;
        if (kind == pzd_pkg::EV_DOWN && finger_tally < int'(pzd_pkg::COUNT_MAX))
            finger_tally++;
        else if (kind == pzd_pkg::EV_UP && finger_tally > 0)
            finger_tally--;
    endtask

    task automatic queue_noise();
        queue_touch(pzd_pkg::KIND_W'($urandom_range(7)), $urandom_range(15),
                    $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    endtask

    // Place a finger at one corner of a square around the center
    task automatic queue_corner(input logic [pzd_pkg::KIND_W-1:0] kind, input int slot,
                                input int cx, input int cy, input int rad);
        int sx;
        int sy;
        sx = (slot == 1 || slot == 2) ? 1 : -1;
        sy = (slot >= 2) ? 1 : -1;
        queue_touch(kind, slot, cx + sx * rad + $urandom_range(7),
                    cy + sy * rad + $urandom_range(7));
    endtask

    // Well-formed pinch with random geometry; some are broken on purpose
    task automatic queue_gesture();
        int cx;
        int cy;
        int rad;
        int placed;
        while (finger_tally > 0)
            queue_touch(pzd_pkg::EV_UP, $urandom_range(3), $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX));
        queue_touch(pzd_pkg::EV_CLEAR, $urandom_range(15), $urandom_range(COORD_MAX),
                    $urandom_range(COORD_MAX));
        cx     = $urandom_range(4000, 61000);
        cy     = $urandom_range(4000, 61000);
        rad    = $urandom_range(50, 3000);
        placed = ($urandom_range(9) == 0) ? NUM_FINGERS - 1 : NUM_FINGERS;
        for (int k = 0; k < placed; k++)
            queue_corner(pzd_pkg::EV_DOWN, k, cx, cy, rad);
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(3))
                0: rad = rad + $urandom_range(60) - 30;
                1: rad = rad + $urandom_range(3000) - 1500;
                2: rad = $urandom_range(32000);
                default: ;
            endcase
            if (rad < 0)
                rad = 0;
            for (int k = 0; k < NUM_FINGERS; k++)
            begin
                if ($urandom_range(3) != 0)
                    queue_corner(pzd_pkg::EV_MOTION, k, cx, cy, rad);
            end
            if ($urandom_range(7) == 0)
                queue_noise();
            queue_touch(pzd_pkg::EV_FRAME, $urandom_range(15), $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX));
        end
        // Cancel by event or by a fifth finger now and then
        case ($urandom_range(9))
            0: queue_touch(pzd_pkg::EV_CANCEL, $urandom_range(15), 0, 0);
            1: queue_touch(pzd_pkg::EV_DOWN, $urandom_range(NUM_FINGERS, 15),
                           $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
            default: ;
        endcase
        while (finger_tally > 0)
            queue_touch(pzd_pkg::EV_UP, $urandom_range(3), $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX));
        if ($urandom_range(1) == 0)
            queue_touch(pzd_pkg::EV_CLEAR, 0, 0, 0);
    endtask

    // Pile of downs to drive the finger count into saturation
    task automatic queue_pile();
        repeat ($urandom_range(16, 18))
            queue_touch(pzd_pkg::EV_DOWN, $urandom_range(15), $urandom_range(COORD_MAX),
                        $urandom_range(COORD_MAX));
        queue_touch(pzd_pkg::EV_FRAME, 0, 0, 0);
        while (finger_tally > 0)
            queue_touch(pzd_pkg::EV_UP, $urandom_range(15), 0, 0);
    endtask

    task automatic queue_random_mix(input int n_items);
        int target;
        int unsigned pick;
        target = touches_queued + n_items;
        while (touches_queued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                queue_gesture();
            else if (pick < 93)
                repeat ($urandom_range(1, 6)) queue_noise();
            else
                queue_pile();
        end
    endtask

    // Wait until every queued touch is sent and every outcome is back
    task automatic wait_drained();
        while (queued_touches.size() != 0 || evt_valid || pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(input logic [pzd_pkg::THRESH_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {pzd_pkg::REG_ZOOM_THRESHOLD, 2'b00};
        pwdata  <= pzd_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        zoom_thr  = value;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [pzd_pkg::THRESH_W-1:0] thr, input int send_pct,
                             input int recv_pct, input int n_items);
        write_threshold(thr);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random_mix(n_items);
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        fingers_down = '0;
        reset_gesture();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, ignored slots, start, updates, cancel, count floor
        queue_touch(pzd_pkg::EV_CLEAR, 0, 0, 0);
        queue_touch(pzd_pkg::EV_DOWN, 0, 0, 0);
        queue_touch(pzd_pkg::EV_DOWN, 1, COORD_MAX, COORD_MAX);
        queue_touch(pzd_pkg::EV_DOWN, 9, 1234, 4321);
        queue_touch(pzd_pkg::EV_DOWN, 2, COORD_MAX, 0);
        queue_touch(pzd_pkg::EV_MOTION, 3, 0, COORD_MAX);
        queue_touch(pzd_pkg::EV_MOTION, 15, COORD_MAX, COORD_MAX);
        queue_touch(pzd_pkg::EV_FRAME, 0, 0, 0);
        queue_touch(pzd_pkg::EV_FRAME, 7, 100, 100);
        queue_touch(pzd_pkg::EV_MOTION, 0, 32768, 32768);
        queue_touch(pzd_pkg::EV_FRAME, 0, 0, 0);
        queue_touch(pzd_pkg::EV_CANCEL, 0, 0, 0);
        queue_touch(pzd_pkg::EV_MOTION, 1, 0, 0);
        queue_touch(pzd_pkg::EV_FRAME, 0, 0, 0);
        queue_touch(pzd_pkg::EV_DOWN, 3, 500, 500);
        repeat (5) queue_touch(pzd_pkg::EV_UP, 0, 0, 0);
        queue_touch(pzd_pkg::EV_UP, 2, 0, 0);
        queue_touch(EV_SPARE_LO, 15, COORD_MAX, COORD_MAX);
        queue_touch(EV_SPARE_HI, 0, 0, 0);
        wait_drained();

        // Random phases over thresholds and idle patterns
        run_phase('0, 0, 0, 130);
        run_phase(pzd_pkg::THRESH_W'(COORD_MAX), 70, 0, 130);
        run_phase(pzd_pkg::THRESH_W'($urandom_range(1, 2000)), 0, 70, 130);
        run_phase(pzd_pkg::THRESH_RESET, 26, 26, 130);
        pressure_go = 1'b1;
        run_phase(pzd_pkg::THRESH_W'($urandom_range(16, 600)), 0, 0, 130);
        run_phase(pzd_pkg::THRESH_RESET, 0, 0, 140);

        repeat (8) @(posedge clk);
        if (pending_outcomes.size() != 0)
            log_mismatch($sformatf("%0d outcomes never arrived", pending_outcomes.size()));
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
